// File: src/chrl_pkg.sv
package chrl_pkg;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;

  localparam logic [1:0] OP_KEY = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = {{24{b[7]}}, b};
    return (h ^ x) * FNV_PRIME;
  endfunction

  function automatic logic [31:0] final_mix(input logic [31:0] hin);
    logic [31:0] h;
    h = hin;
    h = h + (h << 13);
    h = h ^ (h >> 7);
    h = h + (h << 3);
    h = h ^ (h >> 17);
    h = h + (h << 5);
    return h;
  endfunction
endpackage

// File: src/chrl_ram.sv
module chrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/chrl_name_hash.sv
module chrl_name_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [6:0]  server_num,
  input  logic [6:0]  vnode_num,
  output logic        done,
  output logic [31:0] hash
);
  import chrl_pkg::*;

  typedef enum logic [1:0] {IDLE, RUN, MIX} state_t;

  state_t      state;
  logic [4:0]  pos;
  logic [4:0]  len;
  logic [31:0] acc;
  logic [7:0]  bytes [20];
  logic [7:0]  cur;

  // decimal digits by compare and subtract
  function automatic logic [7:0] dig(input logic [6:0] n, input logic [1:0] k);
    logic [6:0] r;
    logic [3:0] h, t;
    h = 4'd0;
    t = 4'd0;
    r = n;
    if (r >= 7'd100) begin
      h = 4'd1;
      r = r - 7'd100;
    end
    if (r >= 7'd80) begin
      t = t | 4'd8;
      r = r - 7'd80;
    end
    if (r >= 7'd40) begin
      t = t | 4'd4;
      r = r - 7'd40;
    end
    if (r >= 7'd20) begin
      t = t | 4'd2;
      r = r - 7'd20;
    end
    if (r >= 7'd10) begin
      t = t | 4'd1;
      r = r - 7'd10;
    end
    case (k)
      2'd0: dig = 8'h30 + {4'd0, h};
      2'd1: dig = 8'h30 + {4'd0, t};
      default: dig = 8'h30 + {1'b0, r};
    endcase
  endfunction

  always_comb begin
    logic [4:0] p;
    for (int i = 0; i < 20; i++) begin
      bytes[i] = 8'h00;
    end
    bytes[0] = 8'h53; bytes[1] = 8'h48; bytes[2] = 8'h41;
    bytes[3] = 8'h52; bytes[4] = 8'h44; bytes[5] = 8'h2d;
    p = 5'd6;
    if (server_num >= 7'd100) begin
      bytes[p] = dig(server_num, 2'd0); p = p + 5'd1;
    end
    if (server_num >= 7'd10) begin
      bytes[p] = dig(server_num, 2'd1); p = p + 5'd1;
    end
    bytes[p] = dig(server_num, 2'd2); p = p + 5'd1;
    bytes[p] = 8'h4e; bytes[p + 5'd1] = 8'h4f; bytes[p + 5'd2] = 8'h44;
    bytes[p + 5'd3] = 8'h45; bytes[p + 5'd4] = 8'h2d;
    p = p + 5'd5;
    if (vnode_num >= 7'd100) begin
      bytes[p] = dig(vnode_num, 2'd0); p = p + 5'd1;
    end
    if (vnode_num >= 7'd10) begin
      bytes[p] = dig(vnode_num, 2'd1); p = p + 5'd1;
    end
    bytes[p] = dig(vnode_num, 2'd2); p = p + 5'd1;
    len = p;
    cur = bytes[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            acc <= FNV_BASIS;
            pos <= 5'd0;
            state <= RUN;
          end
        end
        RUN: begin
          acc <= fold_byte(acc, cur);
          pos <= pos + 5'd1;
          if (pos + 5'd1 == len) begin
            state <= MIX;
          end
        end
        MIX: begin
          hash <= final_mix(acc);
          done <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// File: src/consistent_hash_ring_lookup_core.sv
// a key byte without last is folded in IDLE; a lookup runs MIX, WALK, LAST and RESULT
// add: per vnode HSTART, HWAIT for the name hash, a SCAN walk, SLAST, INSERT and NEXTV
// remove: same per vnode without the INSERT state; throughput one request at a time
// one ring memory port pair sets the walk length; synchronous active-high reset
// clears valid bits and server count, reloads accumulator and sets vnode register to 4
module consistent_hash_ring_lookup_core #(
  parameter int MAX_SERVERS = 16,
  parameter int MAX_VNODES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  key_byte,
  input  logic        key_last,
  input  logic [3:0]  server_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  server,
  output logic [31:0] ring_point,
  output logic [31:0] key_hash,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);
  import chrl_pkg::*;

  localparam int DEPTH = MAX_SERVERS * MAX_VNODES;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(MAX_SERVERS + 1);
  localparam int VW = $clog2(MAX_VNODES + 1);

  typedef enum logic [3:0] {
    IDLE, MIX, WALK, LAST, HSTART, HWAIT, SCAN, SLAST, INSERT, NEXTV, RESULT
  } state_t;

  state_t state;
  logic [DEPTH-1:0] valid_bits;
  logic [CW-1:0] server_count;
  logic [31:0] acc;
  logic [4:0] vnodes;
  logic [1:0] cur_op;
  logic [3:0] cur_srv;
  logic [6:0] vn;
  logic [AW:0] addr;
  logic [AW-1:0] raddr;
  logic [AW-1:0] prev;
  logic [AW-1:0] free_slot;
  logic free_found;
  logic present;
  logic [31:0] kh, best, low, target;
  logic [3:0] bsrv, lsrv;
  logic found, any;
  logic hstart, hdone;
  logic [31:0] hval;
  logic [31:0] rd_hash;
  logic [3:0] rd_srv;
  logic we;
  logic [VW-1:0] eff_v;

  assign eff_v = (int'(vnodes) > MAX_VNODES) ? VW'(MAX_VNODES) : VW'(vnodes);
  assign in_stall = (state != IDLE) || out_valid;
  assign cfg_ready = 1'b1;
  assign raddr = addr[AW-1:0];
  assign hstart = (state == HSTART);
  assign we = (state == INSERT) && free_found && !present;

  chrl_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_hash_ram (
    .clk(clk), .we(we), .waddr(free_slot), .wdata(target),
    .raddr(raddr), .rdata(rd_hash)
  );

  chrl_ram #(.WIDTH(4), .DEPTH(DEPTH)) u_srv_ram (
    .clk(clk), .we(we), .waddr(free_slot), .wdata(cur_srv),
    .raddr(raddr), .rdata(rd_srv)
  );

  chrl_name_hash u_name (
    .clk(clk), .rst(rst), .start(hstart),
    .server_num({3'd0, cur_srv}), .vnode_num(vn),
    .done(hdone), .hash(hval)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      valid_bits <= '0;
      server_count <= '0;
      acc <= FNV_BASIS;
      vnodes <= 5'd4;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vnodes <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid && !in_stall) begin
            cur_op <= op;
            vn <= 7'd0;
            addr <= '0;
            found <= 1'b0;
            any <= 1'b0;
            present <= 1'b0;
            free_found <= 1'b0;
            if (op == OP_KEY) begin
              acc <= fold_byte(acc, key_byte);
              if (key_last) begin
                state <= MIX;
              end
            end else if (op == OP_ADD) begin
              cur_srv <= server_index;
              if (server_count >= CW'(MAX_SERVERS)) begin
                server <= '0; ring_point <= '0; key_hash <= '0; status <= ST_FULL;
                out_valid <= 1'b1;
              end else begin
                state <= (eff_v == '0) ? RESULT : HSTART;
              end
            end else if (op == OP_REMOVE) begin
              if (server_count == '0) begin
                server <= '0; ring_point <= '0; key_hash <= '0; status <= ST_NONE;
                out_valid <= 1'b1;
              end else begin
                cur_srv <= 4'(server_count - CW'(1));
                state <= (eff_v == '0) ? RESULT : HSTART;
              end
            end
          end
        end
        MIX: begin
          kh <= final_mix(acc);
          acc <= FNV_BASIS;
          addr <= addr + (AW + 1)'(1);
          prev <= '0;
          state <= (DEPTH == 1) ? LAST : WALK;
        end
        WALK, LAST: begin
          if (valid_bits[prev]) begin
            any <= 1'b1;
            if (!any || rd_hash < low) begin
              low <= rd_hash; lsrv <= rd_srv;
            end
            if (rd_hash >= kh && (!found || rd_hash < best)) begin
              best <= rd_hash; bsrv <= rd_srv; found <= 1'b1;
            end
          end
          prev <= raddr;
          addr <= addr + (AW + 1)'(1);
          if (state == LAST) begin
            state <= RESULT;
          end else if (addr == (AW + 1)'(DEPTH - 1)) begin
            state <= LAST;
          end
        end
        HSTART: state <= HWAIT;
        HWAIT: begin
          if (hdone) begin
            target <= hval;
            addr <= (AW + 1)'(1);
            prev <= '0;
            present <= 1'b0;
            free_found <= 1'b0;
            state <= (DEPTH == 1) ? SLAST : SCAN;
          end
        end
        SCAN, SLAST: begin
          if (valid_bits[prev] && rd_hash == target) begin
            present <= 1'b1;
            if (cur_op == OP_REMOVE) begin
              valid_bits[prev] <= 1'b0;
            end
          end
          if (!valid_bits[prev] && !free_found) begin
            free_found <= 1'b1;
            free_slot <= prev;
          end
          prev <= raddr;
          addr <= addr + (AW + 1)'(1);
          if (state == SLAST) begin
            state <= (cur_op == OP_ADD) ? INSERT : NEXTV;
          end else if (addr == (AW + 1)'(DEPTH - 1)) begin
            state <= SLAST;
          end
        end
        INSERT: begin
          if (free_found && !present) begin
            valid_bits[free_slot] <= 1'b1;
          end
          state <= NEXTV;
        end
        NEXTV: begin
          addr <= '0;
          if (vn + 7'd1 >= 7'(eff_v)) begin
            state <= RESULT;
          end else begin
            vn <= vn + 7'd1;
            state <= HSTART;
          end
        end
        RESULT: begin
          if (cur_op == OP_KEY) begin
            key_hash <= kh;
            if (!any) begin
              server <= '0; ring_point <= '0; status <= ST_EMPTY;
            end else if (found) begin
              server <= bsrv; ring_point <= best; status <= ST_OK;
            end else begin
              server <= lsrv; ring_point <= low; status <= ST_OK;
            end
          end else begin
            server <= cur_srv; ring_point <= '0; key_hash <= '0; status <= ST_OK;
            if (cur_op == OP_ADD) begin
              server_count <= server_count + CW'(1);
            end else begin
              server_count <= server_count - CW'(1);
            end
          end
          out_valid <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// File: src/chrl_checker.sv
module chrl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  server,
  input logic [31:0] ring_point,
  input logic [1:0]  status
);
  import chrl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(server) && $stable(status))
    else $error("result dropped");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request taken with result pending");
  a_empty_pt: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> ring_point == 32'd0 && server == 4'd0)
    else $error("empty ring result nonzero");
  a_err_srv: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_NONE) |-> server == 4'd0)
    else $error("error result carries server");
endmodule

bind consistent_hash_ring_lookup_core chrl_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .server(server),
  .ring_point(ring_point), .status(status)
);

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import chrl_pkg::*;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] key_byte;
    logic       key_last;
    logic [3:0] server_index;
  } request_t;

  typedef struct packed {
    logic [3:0]  server;
    logic [31:0] ring_point;
    logic [31:0] key_hash;
    logic [1:0]  status;
  } answer_t;

  localparam int RING_SLOTS = 256;
  localparam int SERVER_LIMIT = 16;
  localparam int VNODE_LIMIT = 16;
  localparam int CYCLE_LIMIT = 8000000;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  logic clk, rst;
  logic in_valid, in_stall, key_last, out_valid, out_stall, cfg_valid, cfg_ready;
  logic [1:0] op, status;
  logic [7:0] key_byte;
  logic [3:0] server_index, server;
  logic [31:0] ring_point, key_hash;
  logic [4:0] cfg_data;

  consistent_hash_ring_lookup_core uut (.*);

  // predictor state
  logic [31:0] ring_hash [RING_SLOTS];
  logic [3:0]  ring_owner [RING_SLOTS];
  logic        ring_used [RING_SLOTS];
  logic [4:0]  live_servers;
  logic [31:0] key_acc;
  logic [4:0]  vnode_setting;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int errors, cycles, gap, hold, stall_left;

  function automatic logic [31:0] fold(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = {{24{b[7]}}, b};
    return (h ^ x) * 32'd16777619;
  endfunction

  function automatic logic [31:0] mix(input logic [31:0] hin);
    logic [31:0] h;
    h = hin;
    h = h + (h << 13);
    h = h ^ (h >> 7);
    h = h + (h << 3);
    h = h ^ (h >> 17);
    h = h + (h << 5);
    return h;
  endfunction

  function automatic logic [31:0] fold_number(input logic [31:0] h, input int n);
    if (n >= 10) h = fold(h, 8'(48 + n / 10));
    return fold(h, 8'(48 + n % 10));
  endfunction

  function automatic logic [31:0] vnode_name_hash(input int srv, input int vn);
    logic [31:0] h;
    string a, b;
    a = "SHARD-";
    b = "NODE-";
    h = 32'd2166136261;
    foreach (a[k]) h = fold(h, a[k]);
    h = fold_number(h, srv);
    foreach (b[k]) h = fold(h, b[k]);
    h = fold_number(h, vn);
    return mix(h);
  endfunction

  function automatic int active_vnodes();
    return vnode_setting > VNODE_LIMIT ? VNODE_LIMIT : vnode_setting;
  endfunction

  task automatic predict_ring(input request_t r);
    answer_t a;
    logic [31:0] kh, h, best, low;
    logic [3:0] bsrv, lsrv;
    bit found, any, present;
    a = '0;
    if (r.op == OP_KEY) begin
      key_acc = fold(key_acc, r.key_byte);
      if (!r.key_last) return;
      kh = mix(key_acc);
      key_acc = 32'd2166136261;
      found = 0; any = 0; best = 0; low = 0; bsrv = 0; lsrv = 0;
      for (int i = 0; i < RING_SLOTS; i++) begin
        if (!ring_used[i]) continue;
        if (!any || ring_hash[i] < low) begin
          low = ring_hash[i]; lsrv = ring_owner[i]; any = 1;
        end
        if (ring_hash[i] >= kh && (!found || ring_hash[i] < best)) begin
          best = ring_hash[i]; bsrv = ring_owner[i]; found = 1;
        end
      end
      a.key_hash = kh;
      if (!any) a.status = ST_EMPTY;
      else if (found) begin a.server = bsrv; a.ring_point = best; end
      else begin a.server = lsrv; a.ring_point = low; end
      expected_answers.push_back(a);
    end else if (r.op == OP_ADD) begin
      if (live_servers >= SERVER_LIMIT) begin
        a.status = ST_FULL;
      end else begin
        for (int j = 0; j < active_vnodes(); j++) begin
          h = vnode_name_hash(r.server_index, j);
          present = 0;
          for (int i = 0; i < RING_SLOTS; i++)
            if (ring_used[i] && ring_hash[i] == h) present = 1;
          if (present) continue;
          for (int i = 0; i < RING_SLOTS; i++)
            if (!ring_used[i]) begin
              ring_used[i] = 1; ring_hash[i] = h; ring_owner[i] = r.server_index;
              break;
            end
        end
        live_servers++;
        a.server = r.server_index;
      end
      expected_answers.push_back(a);
    end else if (r.op == OP_REMOVE) begin
      if (live_servers == 0) begin
        a.status = ST_NONE;
      end else begin
        for (int j = 0; j < active_vnodes(); j++) begin
          h = vnode_name_hash(live_servers - 1, j);
          for (int i = 0; i < RING_SLOTS; i++)
            if (ring_used[i] && ring_hash[i] == h) ring_used[i] = 0;
        end
        live_servers--;
        a.server = live_servers[3:0];
      end
      expected_answers.push_back(a);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      gap <= 0;
    end else if (in_valid && in_stall) begin
    end else begin
      if (in_valid) begin
        predict_ring(pending_requests.pop_front());
      end
      if (gap > 0 || pending_requests.size() == 0 || hold) begin
        if (gap > 0) gap <= gap - 1;
        in_valid <= 0;
      end else begin
        in_valid <= 1;
        {op, key_byte, key_last, server_index} <= pending_requests[0];
        gap <= pick_gap();
      end
    end
  end

  // answer monitor
  always @(posedge clk) begin
    answer_t w;
    if (rst) begin
      out_stall <= 0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected answer", 32'(server), 32'd0);
        end else begin
          w = expected_answers.pop_front();
          if (server !== w.server) report_mismatch("server", 32'(server), 32'(w.server));
          if (ring_point !== w.ring_point) report_mismatch("ring_point", ring_point, w.ring_point);
          if (key_hash !== w.key_hash) report_mismatch("key_hash", key_hash, w.key_hash);
          if (status !== w.status) report_mismatch("status", 32'(status), 32'(w.status));
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left <= pick_gap();
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic queue_key(input int len);
    for (int k = 0; k < len; k++)
      pending_requests.push_back({OP_KEY, 8'($urandom), k == len - 1, 4'($urandom)});
  endtask

  task automatic queue_op(input logic [1:0] o, input logic [3:0] s);
    pending_requests.push_back({o, 8'($urandom), 1'($urandom), s});
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || in_valid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_vnodes(input logic [4:0] v);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    vnode_setting = v;
  endtask

  task automatic random_phase(input int n);
    int r;
    while (n > 0) begin
      r = $urandom_range(0, 19);
      if (r < 12) begin
        queue_key($urandom_range(1, 6)); n -= 3;
      end else if (r < 15) begin
        queue_op(OP_ADD, live_servers < 10 ? 4'(live_servers) : 4'($urandom)); n--;
      end else if (r < 18) begin
        queue_op(OP_REMOVE, 4'($urandom)); n--;
      end else begin
        queue_op(OP_UNKNOWN, 4'($urandom)); n--;
      end
    end
  endtask

  initial begin
    logic [4:0] settings [6];
    errors = 0; cycles = 0; hold = 0;
    in_valid = 0; op = 0; key_byte = 0; key_last = 0; server_index = 0;
    out_stall = 0; cfg_valid = 0; cfg_data = 0;
    for (int i = 0; i < RING_SLOTS; i++) begin
      ring_used[i] = 0; ring_hash[i] = 0; ring_owner[i] = 0;
    end
    live_servers = 0; key_acc = 32'd2166136261; vnode_setting = 4;
    rst = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty lookup, empty remove, extremes of key bytes, unknown op, adds past a full table, removes
    pending_requests.push_back({OP_KEY, 8'h00, 1'b1, 4'h0});
    queue_op(OP_REMOVE, 4'h0);
    pending_requests.push_back({OP_KEY, 8'hff, 1'b0, 4'hf});
    pending_requests.push_back({OP_KEY, 8'h80, 1'b0, 4'h0});
    queue_op(OP_ADD, 4'hf);
    queue_op(OP_UNKNOWN, 4'h5);
    pending_requests.push_back({OP_KEY, 8'h7f, 1'b1, 4'h0});
    queue_op(OP_ADD, 4'hf);
    queue_op(OP_ADD, 4'h0);
    for (int s = 1; s < 16; s++) queue_op(OP_ADD, 4'(s));
    queue_key(3);
    queue_op(OP_REMOVE, 4'h0);
    queue_op(OP_REMOVE, 4'h0);
    drain();

    settings = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd8, 5'd4};
    foreach (settings[p]) begin
      write_vnodes(settings[p]);
      random_phase(270);
      if (p == 2) begin
        // sender waits until every expected result is back
        repeat (300) @(posedge clk);
        hold = 1;
        while (in_valid || expected_answers.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        hold = 0;
      end
      drain();
      while (live_servers != 0) begin
        queue_op(OP_REMOVE, 4'h0);
        drain();
      end
    end
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// File: files.f
src/chrl_pkg.sv
src/chrl_ram.sv
src/chrl_name_hash.sv
src/consistent_hash_ring_lookup_core.sv
src/chrl_checker.sv
test/testbench.sv
